FILE: hw/rtl/gain_ramp_normalizer_defines.svh
// ---------------------------------------------------------------------------
// Gain ramp normaliser assertion macros
// Shared concurrent assertion forms used by the gain ramp normaliser RTL.
// ---------------------------------------------------------------------------
`ifndef GAIN_RAMP_NORMALIZER_DEFINES_SVH
`define GAIN_RAMP_NORMALIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GRN_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("gain ramp normaliser assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GRN_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("gain ramp normaliser assertion failed");

`endif

FILE: hw/rtl/grn_pkg.sv
// ---------------------------------------------------------------------------
// Gain ramp normaliser package
// Payload types, fixed-point constants and shared helpers.
// ---------------------------------------------------------------------------
package grn_pkg;

    // Gain format: signed Q(64-F).F with F fraction bits (16..32).
    localparam int GAIN_FRAC_BITS = 32;
    localparam int GAIN_W         = 64;
    localparam int SAMPLE_W       = 32;
    localparam int IPART_SHIFT    = SAMPLE_W - GAIN_FRAC_BITS;

    // Configuration port.
    localparam int CFG_W       = 31;
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EFFECT_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_VOLUME  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_VOLUME    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_FRAMES = 2'd3;

    localparam int PCT_W    = 30;
    localparam int REGION_W = 31;

    // Effect modes.
    localparam logic MODE_RAMP      = 1'b0;
    localparam logic MODE_NORMALISE = 1'b1;

    // Beat kinds.
    localparam logic KIND_SCAN  = 1'b0;
    localparam logic KIND_APPLY = 1'b1;

    // Divider geometry: region_frames * 100 stays below 2^38.
    localparam int DIV_DIVIDEND_W = 64;
    localparam int DIV_DIVISOR_W  = 38;
    localparam int DIV_CNT_W      = $clog2(DIV_DIVIDEND_W);

    // Fixed-point constants.
    localparam logic [GAIN_W-1:0] GAIN_ONE = 64'd1 << GAIN_FRAC_BITS;
    localparam logic [GAIN_W-1:0] NORM_NUMERATOR = 64'h7fff_ffff << GAIN_FRAC_BITS;
    localparam logic [DIV_DIVISOR_W-1:0] PCT_SCALE = 38'd100;
    localparam logic [SAMPLE_W-1:0] PEAK_FULL_SCALE = 32'h7fff_ffff;
    localparam logic [GAIN_W-1:0] BIG_LIMIT = 64'd1 << 40;
    localparam logic [GAIN_W-1:0] POS_LIMIT = 64'h0000_0000_7fff_ffff;
    localparam logic [GAIN_W-1:0] NEG_LIMIT = 64'h0000_0000_8000_0000;
    localparam logic [SAMPLE_W-1:0] FRAC_MASK = 32'hffff_ffff >> IPART_SHIFT;
    localparam logic [SAMPLE_W-1:0] SAT_POS = 32'h7fff_ffff;
    localparam logic [SAMPLE_W-1:0] SAT_NEG = 32'h8000_0000;

    // One input beat.
    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       pass_start;
        logic                       frame_end;
    } grn_in_t;

    // One result beat.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clipped;
        logic                       frame_last;
    } grn_out_t;

    // Request to the shared divider.
    typedef struct packed {
        logic                      start;
        logic [DIV_DIVIDEND_W-1:0] dividend;
        logic [DIV_DIVISOR_W-1:0]  divisor;
    } grn_div_req_t;

    // Step controls for the scaling datapath.
    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic sum;
    } grn_scale_ctl_t;

    // Magnitude of a two's complement sample; the most negative value
    // maps to 2^31, which still fits the unsigned result.
    function automatic logic [SAMPLE_W-1:0] grn_mag32(input logic [SAMPLE_W-1:0] v);
        grn_mag32 = v[SAMPLE_W-1] ? (~v + 32'd1) : v;
    endfunction

endpackage

FILE: hw/rtl/gain_ramp_normalizer.sv
// ---------------------------------------------------------------------------
// Gain ramp normaliser
// Linear fade or peak normalisation of signed 32-bit audio samples.
// ---------------------------------------------------------------------------
// The block takes one beat at a time. A scan beat updates the peak and is
// done in the cycle it is taken. An apply beat runs in steps: one shared
// 32x32 multiplier forms the two partial products of sample times the
// Q32.32 gain one after the other, then they are summed and saturated. An
// apply beat that opens a pass first runs the bit-serial divider: one
// division in normalise mode (none when the peak is zero or full scale),
// two in ramp mode (start gain, then ramp step). A finished result sits in
// an output register, so the next beat is taken while it waits; a second
// result waits in the last step until that register is free.
// Configuration may only be written while the block is idle.
`include "gain_ramp_normalizer_defines.svh"

module gain_ramp_normalizer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [grn_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [grn_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  grn_pkg::grn_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output grn_pkg::grn_out_t                  out_data
);
    import grn_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DIV_GAIN = 8'b0000_0010,
        S_DIV_STEP = 8'b0000_0100,
        S_MAG      = 8'b0000_1000,
        S_MUL_LO   = 8'b0001_0000,
        S_MUL_HI   = 8'b0010_0000,
        S_SUM      = 8'b0100_0000,
        S_FIN      = 8'b1000_0000
    } grn_state_t;

    // Saturating signed 64-bit add.
    function automatic logic [GAIN_W-1:0] sat_add64(input logic [GAIN_W-1:0] a,
                                                    input logic [GAIN_W-1:0] b);
        logic [GAIN_W-1:0] s;
        s = a + b;
        if ((a[GAIN_W-1] == b[GAIN_W-1]) && (s[GAIN_W-1] != a[GAIN_W-1]))
        begin
            sat_add64 = a[GAIN_W-1] ? {1'b1, {(GAIN_W-1){1'b0}}} : {1'b0, {(GAIN_W-1){1'b1}}};
        end
        else
        begin
            sat_add64 = s;
        end
    endfunction

    grn_state_t state_reg, state_next;

    logic                effect_mode_reg;
    logic [PCT_W-1:0]    start_pct_reg;
    logic [PCT_W-1:0]    end_pct_reg;
    logic [REGION_W-1:0] region_frames_reg;

    logic [SAMPLE_W-1:0] peak_reg, peak_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic [GAIN_W-1:0]   step_reg, step_next;

    logic [SAMPLE_W-1:0] sample_reg;
    logic                frame_end_reg;

    logic                out_valid_reg, out_valid_next;
    grn_out_t            out_data_reg;

    logic                in_accept;
    logic                out_free;
    logic [SAMPLE_W-1:0] in_smag;
    logic                norm_unity;
    logic                ramp_neg;
    logic [PCT_W-1:0]    ramp_mag;
    logic [REGION_W-1:0] region_eff;
    logic [DIV_DIVISOR_W-1:0] ramp_den;

    grn_div_req_t        div_req;
    logic                div_done;
    logic [GAIN_W-1:0]   div_quotient;

    grn_scale_ctl_t      scale_ctl;
    logic [SAMPLE_W-1:0] scale_result;
    logic                scale_clip;

    // Handshakes.
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Pass set-up terms.
    assign in_smag    = grn_mag32(in_data.sample_in);
    assign norm_unity = (peak_reg == '0) || (peak_reg >= PEAK_FULL_SCALE);
    assign ramp_neg   = end_pct_reg < start_pct_reg;
    assign ramp_mag   = ramp_neg ? (start_pct_reg - end_pct_reg) : (end_pct_reg - start_pct_reg);
    assign region_eff = (region_frames_reg == '0) ? REGION_W'(1) : region_frames_reg;
    assign ramp_den   = DIV_DIVISOR_W'(region_eff) * PCT_SCALE;

    // Divider requests: start gain or normalise gain from idle, ramp step next.
    always_comb
    begin
        div_req.start = 1'b0;
        if (state_reg == S_IDLE)
        begin
            div_req.start = in_accept && (in_data.kind == KIND_APPLY) && in_data.pass_start
                            && !((effect_mode_reg == MODE_NORMALISE) && norm_unity);
            if (effect_mode_reg == MODE_NORMALISE)
            begin
                div_req.dividend = NORM_NUMERATOR;
                div_req.divisor  = DIV_DIVISOR_W'(peak_reg);
            end
            else
            begin
                div_req.dividend = DIV_DIVIDEND_W'(start_pct_reg) << GAIN_FRAC_BITS;
                div_req.divisor  = PCT_SCALE;
            end
        end
        else
        begin
            div_req.start    = (state_reg == S_DIV_GAIN) && div_done
                               && (effect_mode_reg == MODE_RAMP);
            div_req.dividend = DIV_DIVIDEND_W'(ramp_mag) << GAIN_FRAC_BITS;
            div_req.divisor  = ramp_den;
        end
    end

    grn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (in_data.kind == KIND_APPLY))
                begin
                    if (in_data.pass_start
                        && !((effect_mode_reg == MODE_NORMALISE) && norm_unity))
                    begin
                        state_next = S_DIV_GAIN;
                    end
                    else
                    begin
                        state_next = S_MAG;
                    end
                end
            end
            S_DIV_GAIN:
            begin
                if (div_done)
                begin
                    state_next = (effect_mode_reg == MODE_NORMALISE) ? S_MAG : S_DIV_STEP;
                end
            end
            S_DIV_STEP:
            begin
                if (div_done)
                begin
                    state_next = S_MAG;
                end
            end
            S_MAG:    state_next = S_MUL_LO;
            S_MUL_LO: state_next = S_MUL_HI;
            S_MUL_HI: state_next = S_SUM;
            S_SUM:    state_next = S_FIN;
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Peak, gain and step updates.
    always_comb
    begin
        peak_next = peak_reg;
        gain_next = gain_reg;
        step_next = step_reg;
        if ((state_reg == S_IDLE) && in_accept)
        begin
            if (in_data.kind == KIND_SCAN)
            begin
                if (in_data.pass_start || (in_smag > peak_reg))
                begin
                    peak_next = in_smag;
                end
            end
            else if (in_data.pass_start && (effect_mode_reg == MODE_NORMALISE) && norm_unity)
            begin
                gain_next = GAIN_ONE;
                step_next = '0;
            end
        end
        if ((state_reg == S_DIV_GAIN) && div_done)
        begin
            gain_next = div_quotient;
            if (effect_mode_reg == MODE_NORMALISE)
            begin
                step_next = '0;
            end
        end
        if ((state_reg == S_DIV_STEP) && div_done)
        begin
            step_next = ramp_neg ? (~div_quotient + 64'd1) : div_quotient;
        end
        if ((state_reg == S_SUM) && frame_end_reg)
        begin
            gain_next = sat_add64(gain_reg, step_reg);
        end
    end

    // Scaling datapath steps.
    always_comb
    begin
        scale_ctl.load   = (state_reg == S_MAG);
        scale_ctl.mul_lo = (state_reg == S_MUL_LO);
        scale_ctl.mul_hi = (state_reg == S_MUL_HI);
        scale_ctl.sum    = (state_reg == S_SUM);
    end

    grn_scale u_scale (
        .clk    (clk),
        .ctl    (scale_ctl),
        .sample (sample_reg),
        .gain   (gain_reg),
        .result (scale_result),
        .clip   (scale_clip)
    );

    // Output beat valid.
    always_comb
    begin
        if ((state_reg == S_FIN) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state, configuration and gain state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            effect_mode_reg   <= MODE_RAMP;
            start_pct_reg     <= PCT_W'(100);
            end_pct_reg       <= PCT_W'(100);
            region_frames_reg <= REGION_W'(1);
            peak_reg          <= '0;
            gain_reg          <= GAIN_ONE;
            step_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            gain_reg      <= gain_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_EFFECT_MODE:   effect_mode_reg   <= cfg_data[0];
                    CFG_START_VOLUME:  start_pct_reg     <= cfg_data[PCT_W-1:0];
                    CFG_END_VOLUME:    end_pct_reg       <= cfg_data[PCT_W-1:0];
                    CFG_REGION_FRAMES: region_frames_reg <= cfg_data[REGION_W-1:0];
                endcase
            end
        end
    end

    // Beat payload and output register.
    always_ff @(posedge clk)
    begin
        if (in_accept && (in_data.kind == KIND_APPLY))
        begin
            sample_reg    <= in_data.sample_in;
            frame_end_reg <= in_data.frame_end;
        end
        if ((state_reg == S_FIN) && out_free)
        begin
            out_data_reg.sample_out <= scale_result;
            out_data_reg.clipped    <= scale_clip;
            out_data_reg.frame_last <= frame_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A scan beat is finished in the cycle it is taken.
    `GRN_ASSERT_NEXT(a_scan_single_cycle, clk, rst_n, in_accept && (in_data.kind == KIND_SCAN), state_reg == S_IDLE)
    // The divider only completes while the sequencer waits for it.
    `GRN_ASSERT_IMP(a_div_done_in_wait, clk, rst_n, div_done, (state_reg == S_DIV_GAIN) || (state_reg == S_DIV_STEP))
    // A new output beat only appears after the final step.
    `GRN_ASSERT_IMP(a_out_from_fin, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_FIN))

endmodule

FILE: hw/rtl/grn_div.sv
// ---------------------------------------------------------------------------
// Gain ramp normaliser divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`include "gain_ramp_normalizer_defines.svh"

module grn_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  grn_pkg::grn_div_req_t                 req,
    output logic                                  done,
    output logic [grn_pkg::DIV_DIVIDEND_W-1:0]    quotient
);
    import grn_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_DIVIDEND_W - 1);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [DIV_CNT_W-1:0]      count_reg, count_next;
    logic [DIV_DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIV_DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIV_DIVISOR_W-1:0]  divisor_reg, divisor_next;

    logic [DIV_DIVISOR_W:0]    shifted;
    logic [DIV_DIVISOR_W+1:0]  diff;
    logic                      fits;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign shifted = {rem_reg, quo_reg[DIV_DIVIDEND_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor_reg};
    assign fits    = !diff[DIV_DIVISOR_W+1];

    // Iteration control and datapath.
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            count_next   = '0;
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[DIV_DIVISOR_W-1:0] : shifted[DIV_DIVISOR_W-1:0];
            quo_next   = {quo_reg[DIV_DIVIDEND_W-2:0], fits};
            count_next = count_reg + DIV_CNT_W'(1);
            if (count_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Operands and partial results.
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // A new division is only started once the previous one has finished.
    `GRN_ASSERT_IMP(a_div_start_idle, clk, rst_n, req.start, !busy_reg)
    // The final iteration is always followed by the completion pulse.
    `GRN_ASSERT_NEXT(a_div_done_after_last, clk, rst_n, busy_reg && count_reg == DIV_LAST && !req.start, done_reg && !busy_reg)

endmodule

FILE: hw/rtl/grn_scale.sv
// ---------------------------------------------------------------------------
// Gain ramp normaliser scaling datapath
// Sample times gain through one shared 32x32 multiplier, then saturation.
// ---------------------------------------------------------------------------
module grn_scale (
    input  logic                             clk,
    input  grn_pkg::grn_scale_ctl_t          ctl,
    input  logic [grn_pkg::SAMPLE_W-1:0]     sample,
    input  logic [grn_pkg::GAIN_W-1:0]       gain,
    output logic [grn_pkg::SAMPLE_W-1:0]     result,
    output logic                             clip
);
    import grn_pkg::*;

    logic [SAMPLE_W-1:0] smag_reg;
    logic [GAIN_W-1:0]   gmag_reg;
    logic                rneg_reg;
    logic [GAIN_W-1:0]   plo_reg;
    logic [GAIN_W-1:0]   phi_reg;
    logic [GAIN_W-1:0]   top_reg;
    logic [SAMPLE_W-1:0] low_reg;

    logic [SAMPLE_W-1:0] mul_b;
    logic [GAIN_W-1:0]   product;
    logic                big;
    logic [GAIN_W-1:0]   ipart;
    logic [SAMPLE_W-1:0] frac;
    logic [GAIN_W-1:0]   limit;

    // Shared multiplier: low gain word first, high gain word second.
    assign mul_b   = ctl.mul_hi ? gmag_reg[GAIN_W-1:SAMPLE_W] : gmag_reg[SAMPLE_W-1:0];
    assign product = smag_reg * mul_b;

    // Sign-magnitude operands, partial products and their sum.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            smag_reg <= grn_mag32(sample);
            gmag_reg <= gain[GAIN_W-1] ? (~gain + 64'd1) : gain;
            rneg_reg <= sample[SAMPLE_W-1] ^ gain[GAIN_W-1];
        end
        if (ctl.mul_lo)
        begin
            plo_reg <= product;
        end
        if (ctl.mul_hi)
        begin
            phi_reg <= product;
        end
        if (ctl.sum)
        begin
            top_reg <= phi_reg + {32'd0, plo_reg[GAIN_W-1:SAMPLE_W]};
            low_reg <= plo_reg[SAMPLE_W-1:0];
        end
    end

    // Integer part toward zero, then saturation against the signed limit.
    always_comb
    begin
        big   = top_reg > BIG_LIMIT;
        ipart = (top_reg << IPART_SHIFT) | {32'd0, low_reg >> GAIN_FRAC_BITS};
        frac  = low_reg & FRAC_MASK;
        limit = rneg_reg ? NEG_LIMIT : POS_LIMIT;
        clip  = big || (ipart > limit) || ((ipart == limit) && (frac != '0));
        if (clip)
        begin
            result = rneg_reg ? SAT_NEG : SAT_POS;
        end
        else
        begin
            result = rneg_reg ? (~ipart[SAMPLE_W-1:0] + 32'd1) : ipart[SAMPLE_W-1:0];
        end
    end

endmodule

FILE: dv/gain_ramp_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Gain ramp normaliser checker
// Watches the configuration port and both beat channels, keeps its own
// copy of the peak, gain and ramp step, predicts every scaled sample and
// compares each result beat field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module gain_ramp_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [grn_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [grn_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  grn_pkg::grn_in_t                in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  grn_pkg::grn_out_t               out_data,
    output int                              fail_count,
    output int                              pending
);
    import grn_pkg::*;

    // Shadow configuration and datapath state.
    logic                ramp_or_norm;
    logic [PCT_W-1:0]    start_pct;
    logic [PCT_W-1:0]    end_pct;
    logic [REGION_W-1:0] region_len;
    logic [SAMPLE_W-1:0] peak_mag;
    logic [GAIN_W-1:0]   gain_now;
    logic [GAIN_W-1:0]   gain_step;

    // Scaled samples still owed by the block, oldest first.
    grn_out_t scaled_owed[$];

    // One line per mismatch, and the count goes up.
    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
        fail_count++;
    endtask

    // Signed 64-bit addition that sticks at the limits instead of wrapping.
    function automatic logic [GAIN_W-1:0] add_clamped(input logic [GAIN_W-1:0] a,
                                                    input logic [GAIN_W-1:0] b);
        logic [GAIN_W-1:0] s;
        s = a + b;
        if (a[GAIN_W-1] == b[GAIN_W-1] && s[GAIN_W-1] != a[GAIN_W-1])
            return a[GAIN_W-1] ? {1'b1, {(GAIN_W-1){1'b0}}} : {1'b0, {(GAIN_W-1){1'b1}}};
        return s;
    endfunction

    // Gain and step loaded by the first apply beat of a pass.
    task automatic open_pass();
        logic [63:0] divisor;
        logic [63:0] span;
        logic [63:0] quot;
        logic        falling;
        if (ramp_or_norm == MODE_NORMALISE) begin
            if (peak_mag == '0 || peak_mag >= PEAK_FULL_SCALE)
                gain_now = GAIN_ONE;
            else
                gain_now = NORM_NUMERATOR / 64'(peak_mag);
            gain_step = '0;
        end
        else begin
            // A region of no frames counts as one frame.
            divisor = (region_len == '0 ? 64'd1 : 64'(region_len)) * 64'd100;
            falling = end_pct < start_pct;
            span = falling ? 64'(start_pct - end_pct) : 64'(end_pct - start_pct);
            quot = (span << GAIN_FRAC_BITS) / divisor;
            gain_now = (64'(start_pct) << GAIN_FRAC_BITS) / 64'd100;
            gain_step = falling ? -quot : quot;
        end
    endtask

    // Exact product of sample and gain, truncated toward zero, then clamped.
    function automatic grn_out_t scale_sample(input logic [SAMPLE_W-1:0] raw,
                                              input logic last,
                                              input logic [GAIN_W-1:0] g);
        logic [32:0]         smag;
        logic [63:0]         gmag;
        logic [95:0]         prod;
        logic [63:0]         top;
        logic [63:0]         ipart;
        logic [63:0]         limit;
        logic [SAMPLE_W-1:0] frac;
        logic                big;
        logic                neg;
        logic                clip;
        grn_out_t            r;
        smag = raw[SAMPLE_W-1] ? 33'h1_0000_0000 - {1'b0, raw} : {1'b0, raw};
        gmag = g[GAIN_W-1] ? -g : g;
        prod = 96'(smag) * 96'(gmag);
        top = prod[95:32];
        frac = prod[31:0] & FRAC_MASK;
        big = top > BIG_LIMIT;
        ipart = big ? 64'd0 : 64'(prod >> GAIN_FRAC_BITS);
        neg = raw[SAMPLE_W-1] != g[GAIN_W-1];
        limit = neg ? NEG_LIMIT : POS_LIMIT;
        clip = big || ipart > limit || (ipart == limit && frac != '0);
        if (clip)
            r.sample_out = neg ? SAT_NEG : SAT_POS;
        else
            r.sample_out = neg ? -ipart[31:0] : ipart[31:0];
        r.clipped = clip;
        r.frame_last = last;
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    // Everything is sampled at the rising edge, before the block updates.
    always @(posedge clk or negedge rst_n)
    begin : watch
        grn_out_t    want;
        logic [32:0] mag;
        if (!rst_n)
        begin
            ramp_or_norm = MODE_RAMP;
            start_pct = PCT_W'(100);
            end_pct = PCT_W'(100);
            region_len = REGION_W'(1);
            peak_mag = '0;
            gain_now = GAIN_ONE;
            gain_step = '0;
            scaled_owed.delete();
        end
        else
        begin
            // Result beat: match against the oldest prediction.
            if (out_valid && !out_stall)
            begin
                if (scaled_owed.size() == 0)
                    note_mismatch("unexpected result beat", out_data.sample_out, '0);
                else
                begin
                    want = scaled_owed.pop_front();
                    if (out_data.sample_out !== want.sample_out)
                        note_mismatch("sample_out", out_data.sample_out, want.sample_out);
                    if (out_data.clipped !== want.clipped)
                        note_mismatch("clipped", 32'(out_data.clipped), 32'(want.clipped));
                    if (out_data.frame_last !== want.frame_last)
                        note_mismatch("frame_last", 32'(out_data.frame_last),
                                      32'(want.frame_last));
                end
            end

            // Register writes.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EFFECT_MODE:   ramp_or_norm = cfg_data[0];
                    CFG_START_VOLUME:  start_pct = cfg_data[PCT_W-1:0];
                    CFG_END_VOLUME:    end_pct = cfg_data[PCT_W-1:0];
                    CFG_REGION_FRAMES: region_len = cfg_data[REGION_W-1:0];
                    default: ;
                endcase
            end

            // Input beat: scan beats track the peak, apply beats owe a result.
            if (in_valid && !in_stall)
            begin
                if (in_data.kind == KIND_SCAN)
                begin
                    mag = in_data.sample_in[SAMPLE_W-1]
                        ? 33'h1_0000_0000 - {1'b0, in_data.sample_in}
                        : {1'b0, in_data.sample_in};
                    if (in_data.pass_start)
                        peak_mag = '0;
                    if (mag > 33'(peak_mag))
                        peak_mag = mag[31:0];
                end
                else
                begin
                    if (in_data.pass_start)
                        open_pass();
                    scaled_owed.push_back(scale_sample(in_data.sample_in,
                                                       in_data.frame_end, gain_now));
                    if (in_data.frame_end)
                        gain_now = add_clamped(gain_now, gain_step);
                end
            end
        end
        pending = scaled_owed.size();
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Gain ramp normaliser testbench
// Drives directed corner beats and then randomised scan and apply passes
// in both effect modes, with random idling on both channels; a separate
// checker predicts every result and counts mismatches for the verdict.
// ---------------------------------------------------------------------------
module testbench;
    import grn_pkg::*;

    localparam logic [PCT_W-1:0]    PCT_TOP     = 30'd1_000_000_000;
    localparam logic [REGION_W-1:0] REGION_TOP  = 31'h7fff_ffff;
    localparam int                  RANDOM_BEATS = 600;
    localparam int                  SETTLE_CYCLES = 16;
    localparam int                  TAIL_CYCLES = 300;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    grn_in_t                in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    grn_out_t               out_data;
    int                     fail_count;
    int                     pending;

    int beats_sent = 0;
    int gap_pct = 20;
    int stall_pct = 20;
    int stall_left = 0;
    bit quiet = 1'b0;

    gain_ramp_normalizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    gain_ramp_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #4 clk = ~clk;

    // Hard limit on the whole run.
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver back-pressure in random bursts; none once the run is quiet.
    always @(negedge clk)
    begin
        if (quiet)
            stall_left = 0;
        else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 9);
        out_stall = stall_left != 0;
        if (stall_left != 0)
            stall_left--;
    end

    // Sample values weighted toward full scale, zero and small magnitudes.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = 32'h7fff_ffff;
            1: v = 32'h8000_0000;
            2: v = 32'd0;
            3:
            begin
                v = 32'($urandom_range(1, 255));
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic logic [PCT_W-1:0] pick_pct();
        logic [PCT_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = '0;
            1: v = PCT_TOP;
            2: v = PCT_W'($urandom_range(0, 1_000_000_000));
            default: v = PCT_W'($urandom_range(0, 300));
        endcase
        return v;
    endfunction

    // One beat on the input channel; returns at the falling edge after it, or after a random idle gap.
    task automatic push_beat(input logic kind, input logic [SAMPLE_W-1:0] smp,
                             input logic first, input logic last);
        int gap;
        in_data.kind = kind;
        in_data.sample_in = smp;
        in_data.pass_start = first;
        in_data.frame_end = last;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        beats_sent++;
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 9);
            repeat (gap) @(negedge clk);
        end
    endtask

    // Hold off until every owed result is out and the last scan has finished.
    task automatic settle();
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Registers change only once the block is idle.
    task automatic set_config(input logic mode, input logic [PCT_W-1:0] s,
                              input logic [PCT_W-1:0] e, input logic [REGION_W-1:0] r);
        settle();
        write_reg(CFG_EFFECT_MODE, CFG_W'(mode));
        write_reg(CFG_START_VOLUME, CFG_W'(s));
        write_reg(CFG_END_VOLUME, CFG_W'(e));
        write_reg(CFG_REGION_FRAMES, CFG_W'(r));
    endtask

    initial
    begin
        int               phase;
        int               n;
        int               chans;
        int               frames;
        logic             up;
        logic [REGION_W-1:0] region;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // After reset: unity gain and no step, even without a pass start.
        push_beat(KIND_APPLY, 32'h7fff_ffff, 1'b0, 1'b0);
        push_beat(KIND_APPLY, 32'h8000_0000, 1'b0, 1'b1);
        // A scan in ramp mode still tracks the peak; the most negative
        // sample gives a peak of 2^31.
        push_beat(KIND_SCAN, 32'h0000_0005, 1'b1, 1'b0);
        push_beat(KIND_SCAN, 32'h8000_0000, 1'b0, 1'b1);
        set_config(MODE_NORMALISE, '0, PCT_TOP, REGION_W'(1));
        push_beat(KIND_APPLY, 32'h0000_0001, 1'b1, 1'b1);
        // Zero peak falls back to unity gain.
        push_beat(KIND_SCAN, 32'd0, 1'b1, 1'b0);
        push_beat(KIND_APPLY, 32'hffff_ffff, 1'b1, 1'b0);
        // Ordinary normalisation to a peak of 1000, with clipping beyond it.
        push_beat(KIND_SCAN, 32'h0000_0003, 1'b1, 1'b0);
        push_beat(KIND_SCAN, 32'hffff_fc18, 1'b0, 1'b1);
        push_beat(KIND_APPLY, 32'd1000, 1'b1, 1'b1);
        push_beat(KIND_APPLY, 32'hffff_fc18, 1'b0, 1'b0);
        push_beat(KIND_APPLY, 32'h7fff_ffff, 1'b0, 1'b0);
        push_beat(KIND_APPLY, 32'h8000_0000, 1'b0, 1'b1);
        // Full-scale peak also falls back to unity gain.
        push_beat(KIND_SCAN, 32'h7fff_ffff, 1'b1, 1'b0);
        push_beat(KIND_APPLY, 32'h7fff_fffe, 1'b1, 1'b1);
        // Ramp upwards over a region of no frames, which counts as one.
        set_config(MODE_RAMP, '0, PCT_TOP, '0);
        push_beat(KIND_APPLY, 32'h0000_0001, 1'b1, 1'b1);
        push_beat(KIND_APPLY, 32'h0000_0001, 1'b0, 1'b1);
        push_beat(KIND_APPLY, 32'hffff_ffff, 1'b0, 1'b1);
        // Largest start gain falling over the longest region.
        set_config(MODE_RAMP, PCT_TOP, '0, REGION_TOP);
        push_beat(KIND_APPLY, 32'h7fff_ffff, 1'b1, 1'b0);
        push_beat(KIND_APPLY, 32'h8000_0000, 1'b0, 1'b0);
        push_beat(KIND_APPLY, 32'd0, 1'b0, 1'b1);

        // Random passes, each under its own register setting.
        n = beats_sent + RANDOM_BEATS;
        phase = 0;
        while (beats_sent < n)
        begin
            quiet = beats_sent >= n - 80;
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 15;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 10;
                default: stall_pct = 35;
            endcase
            case ($urandom_range(0, 4))
                0: region = '0;
                1: region = REGION_W'(1);
                2: region = REGION_TOP;
                3: region = REGION_W'($urandom_range(1, 32'h7fff_ffff));
                default: region = REGION_W'($urandom_range(1, 16));
            endcase

            if (phase == 2)
            begin
                // Gain run-away: the steepest ramp kept going until the gain
                // sticks at a 64-bit limit.
                up = 1'($urandom_range(0, 1));
                set_config(MODE_RAMP, up ? '0 : PCT_TOP, up ? PCT_TOP : '0,
                           up ? '0 : REGION_W'(1));
                for (int i = 0; i < 240; i++)
                    push_beat(KIND_APPLY, pick_sample(), i == 0, 1'b1);
            end
            else if ($urandom_range(0, 1))
            begin
                // Scan pass, then an apply pass; now and then the scan opens
                // without a pass start.
                set_config(MODE_NORMALISE, pick_pct(), pick_pct(), region);
                frames = $urandom_range(1, 12);
                up = 1'($urandom_range(0, 9) != 0);
                for (int i = 0; i < frames; i++)
                    push_beat(KIND_SCAN, pick_sample(), up && i == 0,
                              1'($urandom_range(0, 1)));
                if (phase == 1)
                    settle();
                chans = $urandom_range(1, 2);
                frames = $urandom_range(1, 16);
                for (int i = 0; i < frames; i++)
                    push_beat(KIND_APPLY, pick_sample(), i == 0, (i % chans) == chans - 1);
            end
            else
            begin
                // Ramp pass over whole frames, sometimes carried on without
                // a new pass start.
                set_config(MODE_RAMP, pick_pct(), pick_pct(), region);
                repeat ($urandom_range(0, 2))
                    push_beat(KIND_SCAN, pick_sample(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                chans = $urandom_range(1, 2);
                frames = $urandom_range(1, 12);
                for (int f = 0; f < frames; f++)
                    for (int c = 0; c < chans; c++)
                        push_beat(KIND_APPLY, pick_sample(), f == 0 && c == 0,
                                  c == chans - 1);
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 4))
                        push_beat(KIND_APPLY, pick_sample(), 1'b0, 1'b1);
            end

            // A little noise: beats with every field random.
            repeat ($urandom_range(0, 2))
                push_beat(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            phase++;
        end

        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: gain_ramp_normalizer.f
+incdir+hw/rtl
hw/rtl/grn_pkg.sv
hw/rtl/grn_div.sv
hw/rtl/grn_scale.sv
hw/rtl/gain_ramp_normalizer.sv
dv/gain_ramp_checker.sv
dv/testbench.sv
